FILE: design/pdpmc_pkg.sv
// Package for the PD position motor controller.
// Holds register indexes, reset values, beat layouts and the configuration type.
// Used by every module of the block; depends on nothing.
package pdpmc_pkg;

    localparam int IN_W  = 64;
    localparam int OUT_W = 56;

    localparam int TGT_LSB = 0;
    localparam int ENC_LSB = 32;
    localparam int POS_W   = 32;

    localparam int DUTY_LSB = 0;
    localparam int DRV_LSB  = 8;
    localparam int FWD_LSB  = 17;
    localparam int REV_LSB  = 18;
    localparam int REP_LSB  = 19;
    localparam int REP_W    = 33;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx REG_P_GAIN      = 2'd0;
    localparam t_cfg_idx REG_D_GAIN      = 2'd1;
    localparam t_cfg_idx REG_DEADBAND    = 2'd2;
    localparam t_cfg_idx REG_DRIVE_LIMIT = 2'd3;

    localparam logic [15:0] RST_P_GAIN      = 16'd912;
    localparam logic [15:0] RST_D_GAIN      = 16'd1699;
    localparam logic [15:0] RST_DEADBAND    = 16'd5;
    localparam logic [7:0]  RST_DRIVE_LIMIT = 8'd100;

    typedef struct packed {
        logic [15:0] p_gain;
        logic [15:0] d_gain;
        logic [15:0] deadband;
        logic [7:0]  drive_limit;
    } t_cfg;

endpackage

FILE: design/pdpmc_error_stage.sv
// Input register and error stage of the PD position motor controller.
// Forms the error, its magnitude, the deadband flag and the change of magnitude.
// Depends on pdpmc_pkg.
module pdpmc_error_stage #(
    parameter int POS_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pdpmc_pkg::t_cfg        i_cfg,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [31:0]            i_target,
    input  logic [31:0]            i_encoder,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic signed [POS_BITS:0]   o_err,
    output logic [POS_BITS-1:0]    o_mag,
    output logic signed [POS_BITS:0]   o_diff,
    output logic                   o_inside
);
    import pdpmc_pkg::*;

    localparam int EW = POS_BITS + 1;
    localparam int CW = POS_BITS + 16;

    logic                       r_a_vld;
    logic signed [POS_BITS-1:0] r_tgt;
    logic signed [POS_BITS-1:0] r_enc;
    logic                       r_b_vld;
    logic signed [EW-1:0]       r_err;
    logic [POS_BITS-1:0]        r_mag;
    logic signed [EW-1:0]       r_diff;
    logic                       r_inside;
    logic [POS_BITS-1:0]        r_last;

    logic                       a_rdy;
    logic                       b_rdy;
    logic signed [EW-1:0]       n_err;
    logic [POS_BITS-1:0]        n_mag;
    logic signed [EW-1:0]       n_diff;
    logic                       n_inside;
    logic [EW-1:0]              neg_err;

    assign b_rdy   = !r_b_vld || i_ready;
    assign a_rdy   = !r_a_vld || b_rdy;
    assign o_ready = a_rdy;

    always_comb begin
        n_err    = EW'(r_tgt) - EW'(r_enc);
        neg_err  = -n_err;
        n_mag    = n_err[EW-1] ? neg_err[POS_BITS-1:0] : n_err[POS_BITS-1:0];
        n_diff   = $signed({1'b0, n_mag}) - $signed({1'b0, r_last});
        n_inside = CW'(n_mag) < CW'(i_cfg.deadband);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (a_rdy) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_rdy && i_valid) begin
            r_tgt <= i_target[POS_BITS-1:0];
            r_enc <= i_encoder[POS_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_last  <= '0;
        end else if (b_rdy) begin
            r_b_vld <= r_a_vld;
            if (r_a_vld) begin
                r_last <= n_mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_rdy && r_a_vld) begin
            r_err    <= n_err;
            r_mag    <= n_mag;
            r_diff   <= n_diff;
            r_inside <= n_inside;
        end
    end

    assign o_valid  = r_b_vld;
    assign o_err    = r_err;
    assign o_mag    = r_mag;
    assign o_diff   = r_diff;
    assign o_inside = r_inside;

endmodule

FILE: design/pdpmc_mult_stage.sv
// Gain multiply stage of the PD position motor controller.
// Registers the proportional and derivative products of one beat.
// Depends on pdpmc_pkg.
module pdpmc_mult_stage #(
    parameter int POS_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pdpmc_pkg::t_cfg             i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [POS_BITS:0]    i_err,
    input  logic [POS_BITS-1:0]         i_mag,
    input  logic signed [POS_BITS:0]    i_diff,
    input  logic                        i_inside,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [POS_BITS+15:0]        o_pprod,
    output logic signed [POS_BITS+17:0] o_dprod,
    output logic signed [POS_BITS:0]    o_err,
    output logic                        o_inside
);
    import pdpmc_pkg::*;

    localparam int PW = POS_BITS + 16;
    localparam int DW = POS_BITS + 18;

    logic                    r_vld;
    logic [PW-1:0]           r_pprod;
    logic signed [DW-1:0]    r_dprod;
    logic signed [POS_BITS:0] r_err;
    logic                    r_inside;
    logic                    rdy;

    assign rdy     = !r_vld || i_ready;
    assign o_ready = rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (rdy) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy && i_valid) begin
            r_pprod  <= PW'(i_cfg.p_gain) * PW'(i_mag);
            r_dprod  <= DW'($signed({1'b0, i_cfg.d_gain})) * DW'(i_diff);
            r_err    <= i_err;
            r_inside <= i_inside;
        end
    end

    assign o_valid  = r_vld;
    assign o_pprod  = r_pprod;
    assign o_dprod  = r_dprod;
    assign o_err    = r_err;
    assign o_inside = r_inside;

endmodule

FILE: design/pdpmc_drive_stage.sv
// Drive stage and result register of the PD position motor controller.
// Sums the products, scales toward zero, clamps, and sets direction and error.
// Depends on pdpmc_pkg.
module pdpmc_drive_stage #(
    parameter int POS_BITS       = 32,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pdpmc_pkg::t_cfg             i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [POS_BITS+15:0]        i_pprod,
    input  logic signed [POS_BITS+17:0] i_dprod,
    input  logic signed [POS_BITS:0]    i_err,
    input  logic                        i_inside,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [pdpmc_pkg::OUT_W-1:0] o_data
);
    import pdpmc_pkg::*;

    localparam int SW = POS_BITS + 19;

    logic                 r_vld;
    logic [OUT_W-1:0]     r_data;
    logic                 rdy;

    logic signed [SW-1:0] sum;
    logic [SW-1:0]        neg_sum;
    logic [SW-1:0]        mag_sum;
    logic [SW-1:0]        scaled;
    logic [7:0]           duty;
    logic [8:0]           drive;
    logic                 fwd;
    logic                 rev;
    logic [REP_W-1:0]     rep;
    logic [OUT_W-1:0]     n_data;

    assign rdy     = !r_vld || i_ready;
    assign o_ready = rdy;

    always_comb begin
        sum     = SW'(i_pprod) + SW'(i_dprod);
        neg_sum = -sum;
        mag_sum = sum[SW-1] ? neg_sum : sum;
        scaled  = mag_sum >> GAIN_FRAC_BITS;
        duty    = (scaled > SW'(i_cfg.drive_limit)) ? i_cfg.drive_limit : scaled[7:0];
        drive   = sum[SW-1] ? -{1'b0, duty} : {1'b0, duty};
        fwd     = !i_inside && !i_err[POS_BITS] && (i_err != '0);
        rev     = !i_inside && i_err[POS_BITS];
        rep     = i_inside ? '0 : REP_W'(i_err);
        n_data  = '0;
        n_data[DUTY_LSB +: 8]    = duty;
        n_data[DRV_LSB +: 9]     = drive;
        n_data[FWD_LSB]          = fwd;
        n_data[REV_LSB]          = rev;
        n_data[REP_LSB +: REP_W] = rep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (rdy) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_data;

endmodule

FILE: design/pd_position_motor_control.sv
// Top level of the PD position motor controller.
// Holds the configuration registers and chains the error, multiply and drive stages.
// Depends on pdpmc_pkg, pdpmc_error_stage, pdpmc_mult_stage and pdpmc_drive_stage.
//
// Each input beat is one control tick carrying a target and an encoder position.
// The block accepts one beat per clock cycle when the output is not stalled and
// returns one result beat per tick. The beat is taken into the input register at
// the accepting edge and then passes through the three register stages that
// follow it: the error and magnitude register, the gain product register and the
// result register. Every stage is elastic, so a stalled output fills the pipeline
// before the input deasserts tready. The previous error magnitude is held in the
// error stage and starts at zero after reset. Configuration registers are to be
// written through i_cfg_we only while the block is idle; the block itself does
// not enforce this. Writes apply to every beat that follows.
module pd_position_motor_control #(
    parameter int POS_BITS       = 32,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  pdpmc_pkg::t_cfg_idx         i_cfg_index,
    input  logic [15:0]                 i_cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // Fields from bit 0: target_pos[31:0], encoder_pos[31:0].
    input  logic [pdpmc_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // Fields from bit 0: duty[7:0], drive[8:0], dir_forward, dir_reverse,
    // reported_error[32:0], then zero fill.
    output logic [pdpmc_pkg::OUT_W-1:0] m_axis_tdata
);
    import pdpmc_pkg::*;

    t_cfg r_cfg;

    logic                        e_vld;
    logic                        e_rdy;
    logic signed [POS_BITS:0]    e_err;
    logic [POS_BITS-1:0]         e_mag;
    logic signed [POS_BITS:0]    e_diff;
    logic                        e_inside;

    logic                        m_vld;
    logic                        m_rdy;
    logic [POS_BITS+15:0]        m_pprod;
    logic signed [POS_BITS+17:0] m_dprod;
    logic signed [POS_BITS:0]    m_err;
    logic                        m_inside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.p_gain      <= RST_P_GAIN;
            r_cfg.d_gain      <= RST_D_GAIN;
            r_cfg.deadband    <= RST_DEADBAND;
            r_cfg.drive_limit <= RST_DRIVE_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_P_GAIN:      r_cfg.p_gain      <= i_cfg_data;
                REG_D_GAIN:      r_cfg.d_gain      <= i_cfg_data;
                REG_DEADBAND:    r_cfg.deadband    <= i_cfg_data;
                REG_DRIVE_LIMIT: r_cfg.drive_limit <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    pdpmc_error_stage #(
        .POS_BITS (POS_BITS)
    ) u_error (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_target  (s_axis_tdata[TGT_LSB +: POS_W]),
        .i_encoder (s_axis_tdata[ENC_LSB +: POS_W]),
        .o_valid   (e_vld),
        .i_ready   (e_rdy),
        .o_err     (e_err),
        .o_mag     (e_mag),
        .o_diff    (e_diff),
        .o_inside  (e_inside)
    );

    pdpmc_mult_stage #(
        .POS_BITS (POS_BITS)
    ) u_mult (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (e_vld),
        .o_ready  (e_rdy),
        .i_err    (e_err),
        .i_mag    (e_mag),
        .i_diff   (e_diff),
        .i_inside (e_inside),
        .o_valid  (m_vld),
        .i_ready  (m_rdy),
        .o_pprod  (m_pprod),
        .o_dprod  (m_dprod),
        .o_err    (m_err),
        .o_inside (m_inside)
    );

    pdpmc_drive_stage #(
        .POS_BITS       (POS_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_drive (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (m_vld),
        .o_ready  (m_rdy),
        .i_pprod  (m_pprod),
        .i_dprod  (m_dprod),
        .i_err    (m_err),
        .i_inside (m_inside),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata)
    );

endmodule
